>>> hdl/srecord_line_loader_defines.svh
// Assertion shorthands shared by the loader's modules.
`ifndef SRECORD_LINE_LOADER_DEFINES_SVH
`define SRECORD_LINE_LOADER_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define SLL_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sll: property failed");

// Next-cycle implication, held off while in reset.
`define SLL_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sll: property failed");

`endif

>>> hdl/sll_pkg.sv
`default_nettype none

package sll_pkg;

  localparam int unsigned POS_BITS    = 11;
  localparam int unsigned K_BITS      = POS_BITS - 1;
  localparam int unsigned CHAR_BITS   = 8;
  localparam int unsigned DIGIT_BITS  = 6;
  localparam int unsigned BYTE_BITS   = 10;
  localparam int unsigned COUNT_BITS  = 10;
  localparam int unsigned TYPE_BITS   = 6;
  localparam int unsigned DATA_BITS   = 8;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned SUM_BITS    = 8;
  localparam int unsigned NAB_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned CMP_BITS    = ((K_BITS > COUNT_BITS) ? K_BITS : COUNT_BITS) + 1;
  localparam int unsigned LEN_BITS    = (POS_BITS > COUNT_BITS + 2) ? POS_BITS : COUNT_BITS + 2;

  localparam int unsigned REG_ADDR_BITS = 2;
  localparam int unsigned REG_BITS      = 32;
  localparam logic [REG_ADDR_BITS-1:0] REG_FORCED_BASE = 2'd0;

  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_BITS-1:0]  POS_MAX   = '1;
  localparam logic [CHAR_BITS-1:0] CHAR_S    = 8'h53;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_F = 8'h66;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_UC_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
  localparam logic [SUM_BITS-1:0]  SUM_GOOD  = 8'hFF;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_LENGTH = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD    = 2'd2;

  localparam logic [TYPE_BITS-1:0] TYPE_S0 = 6'd0;
  localparam logic [TYPE_BITS-1:0] TYPE_S1 = 6'd1;
  localparam logic [TYPE_BITS-1:0] TYPE_S2 = 6'd2;
  localparam logic [TYPE_BITS-1:0] TYPE_S3 = 6'd3;
  localparam logic [TYPE_BITS-1:0] TYPE_S5 = 6'd5;
  localparam logic [TYPE_BITS-1:0] TYPE_S7 = 6'd7;
  localparam logic [TYPE_BITS-1:0] TYPE_S8 = 6'd8;
  localparam logic [TYPE_BITS-1:0] TYPE_S9 = 6'd9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_TYPE,
    OP_CNT_HI,
    OP_CNT,
    OP_BYTE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e               op;
    logic                  is_s;
    logic [BYTE_BITS-1:0]  value;
    logic [K_BITS-1:0]     k;
    logic                  last;
    logic [POS_BITS-1:0]   slen;
  } cmd_t;

  typedef struct packed {
    logic                   kind;
    logic [ADDR_BITS-1:0]   write_address;
    logic [DATA_BITS-1:0]   write_data;
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   record_address;
    logic [COUNT_BITS-1:0]  byte_count;
    logic                   checksum_ok;
    logic [TYPE_BITS-1:0]   record_type;
  } res_t;

  // Lenient hex nibble: characters above 'f' or below '0' read as zero; the gaps between the ranges are not rejected.
  function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] d;
    if (c > CHAR_LC_F) begin
      d = '0;
    end else if (c >= CHAR_LC_A) begin
      d = c - CHAR_LC_A + 8'd10;
    end else if (c >= CHAR_UC_A) begin
      d = c - CHAR_UC_A + 8'd10;
    end else if (c >= CHAR_ZERO) begin
      d = c - CHAR_ZERO;
    end else begin
      d = '0;
    end
    return d[DIGIT_BITS-1:0];
  endfunction

  // Address field length in bytes; zero marks an unsupported type.
  function automatic logic [NAB_BITS-1:0] address_bytes(input logic [TYPE_BITS-1:0] t);
    logic [NAB_BITS-1:0] n;
    unique case (t) inside
      TYPE_S0, TYPE_S1, TYPE_S5, TYPE_S9: n = 3'd2;
      TYPE_S2, TYPE_S8:                   n = 3'd3;
      TYPE_S3, TYPE_S7:                   n = 3'd4;
      default:                            n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sll_front.sv
`default_nettype none

module sll_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_push_i,
  input  logic                          q_full_i,
  input  logic [sll_pkg::CHAR_BITS-1:0] char_code_i,
  input  logic                          last_char_i,
  output logic                          cmd_push_o,
  output sll_pkg::cmd_t                 cmd_o
);
  import sll_pkg::*;

  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [DIGIT_BITS-1:0] high_q, high_d;
  logic [DIGIT_BITS-1:0] digit;
  logic [BYTE_BITS-1:0]  byte_val;
  logic                  accept;
  logic                  in_range;

  assign accept = in_push_i && !q_full_i;

  always_comb begin
    digit    = digit_value(char_code_i);
    in_range = (pos_q != POS_MAX);
    byte_val = {high_q, 4'b0000} | BYTE_BITS'(digit);

    cmd_o.op    = OP_NONE;
    cmd_o.is_s  = (char_code_i == CHAR_S);
    cmd_o.value = byte_val;
    cmd_o.k     = pos_q[POS_BITS-1:1] - K_BITS'(1);
    cmd_o.last  = last_char_i;
    cmd_o.slen  = in_range ? pos_q + POS_BITS'(1) : POS_MAX;

    // past the length limit the line is only counted out to its last word
    if (in_range) begin
      if (pos_q == POS_BITS'(0)) begin
        cmd_o.op = OP_START;
      end else if (pos_q == POS_BITS'(1)) begin
        cmd_o.op    = OP_TYPE;
        cmd_o.value = BYTE_BITS'(digit);
      end else if (pos_q == POS_BITS'(2)) begin
        cmd_o.op    = OP_CNT_HI;
        cmd_o.value = {digit, 4'b0000};
      end else if (pos_q == POS_BITS'(3)) begin
        cmd_o.op = OP_CNT;
      end else if (pos_q[0]) begin
        cmd_o.op = OP_BYTE;
      end
    end

    if (last_char_i) begin
      pos_d = '0;
    end else if (in_range) begin
      pos_d = pos_q + POS_BITS'(1);
    end else begin
      pos_d = pos_q;
    end

    high_d = (in_range && !pos_q[0]) ? digit : high_q;
  end

  // high digits stay here, but for the count's, sent as OP_CNT_HI; only words the back end acts on are queued
  assign cmd_push_o = accept && (last_char_i || (cmd_o.op != OP_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      high_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      high_q <= high_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sll_fifo.sv
`default_nettype none

`include "srecord_line_loader_defines.svh"

module sll_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sll_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sll_pkg::cmd_t data_o
);
  import sll_pkg::*;

  cmd_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                              : wr_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                              : rd_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SLL_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !full_o)
  `SLL_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o)
  `SLL_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

>>> hdl/sll_back.sv
`default_nettype none

`include "srecord_line_loader_defines.svh"

module sll_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  sll_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic [sll_pkg::ADDR_BITS-1:0] forced_base_i,
  input  logic                          res_pop_i,
  output logic                          res_valid_o,
  output sll_pkg::res_t                 res_o
);
  import sll_pkg::*;

  logic                  start_bad_q, start_bad_d;
  logic [TYPE_BITS-1:0]  type_q, type_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;

  logic [NAB_BITS-1:0]   nab, nab_l, got, missing;
  logic [CMP_BITS-1:0]   k_c, cnt_c, nab_c, off;
  logic [ADDR_BITS-1:0]  base, waddr, rec_addr;
  logic [LEN_BITS-1:0]   exp_len;
  logic                  wr, produces, out_free, take, len_ok;

  always_comb begin
    nab   = address_bytes(type_q);
    k_c   = CMP_BITS'(cmd_i.k);
    cnt_c = CMP_BITS'(count_q);
    nab_c = CMP_BITS'(nab);
    off   = k_c - nab_c - CMP_BITS'(1);
    base  = (forced_base_i != '0) ? forced_base_i : addr_q;
    waddr = base + ADDR_BITS'(off);

    start_bad_d = start_bad_q;
    type_d      = type_q;
    count_d     = count_q;
    addr_d      = addr_q;
    sum_d       = sum_q;
    wr          = 1'b0;

    unique case (cmd_i.op)
      OP_START: begin
        start_bad_d = !cmd_i.is_s;
        type_d      = '0;
        count_d     = '0;
        addr_d      = '0;
        sum_d       = '0;
      end
      OP_TYPE: begin
        type_d = cmd_i.value[TYPE_BITS-1:0];
      end
      OP_CNT_HI: begin
        count_d = cmd_i.value;
      end
      OP_CNT: begin
        count_d = cmd_i.value;
        sum_d   = sum_q + cmd_i.value[SUM_BITS-1:0];
      end
      OP_BYTE: begin
        if (!start_bad_q && (nab != '0)) begin
          if (k_c <= nab_c) begin
            // decoded bytes may reach ten bits; the top two overlap the shifted field
            addr_d = {addr_q[ADDR_BITS-9:0], 8'h00} | ADDR_BITS'(cmd_i.value);
            sum_d  = sum_q + cmd_i.value[SUM_BITS-1:0];
          end else begin
            wr = (k_c < cnt_c);
            // data bytes and the checksum byte; with no data the checksum sits right
            // after the address
            if ((k_c <= cnt_c) || (k_c == nab_c + CMP_BITS'(1))) begin
              sum_d = sum_q + cmd_i.value[SUM_BITS-1:0];
            end
          end
        end
      end
      default: ;
    endcase

    // end-of-record view uses the state as updated by this word
    nab_l   = address_bytes(type_d);
    got     = (count_d < COUNT_BITS'(nab_l)) ? count_d[NAB_BITS-1:0] : nab_l;
    missing = nab_l - got;
    case (missing)
      3'd0:    rec_addr = addr_d;
      3'd1:    rec_addr = {addr_d[ADDR_BITS-9:0], 8'h00};
      3'd2:    rec_addr = {addr_d[ADDR_BITS-17:0], 16'h0000};
      3'd3:    rec_addr = {addr_d[ADDR_BITS-25:0], 24'h000000};
      default: rec_addr = '0;
    endcase
    exp_len = LEN_BITS'({count_d, 1'b0}) + LEN_BITS'(4);
    len_ok  = (LEN_BITS'(cmd_i.slen) == exp_len);

    res_d = '0;
    if (cmd_i.last) begin
      res_d.kind = KIND_STATUS;
      if (start_bad_d) begin
        res_d.status = STATUS_BAD;
      end else begin
        res_d.byte_count  = count_d;
        res_d.record_type = type_d;
        if (!len_ok) begin
          res_d.status = STATUS_LENGTH;
        end else if (nab_l == '0) begin
          res_d.status = STATUS_BAD;
        end else begin
          res_d.status         = STATUS_OK;
          res_d.record_address = rec_addr;
          res_d.checksum_ok    = (sum_d == SUM_GOOD);
        end
      end
    end else begin
      res_d.kind          = KIND_WRITE;
      res_d.write_address = waddr;
      res_d.write_data    = cmd_i.value[DATA_BITS-1:0];
    end

    // a data byte finished by the line's last character is never sent
    produces = cmd_i.last || wr;
    out_free = !res_valid_q || res_pop_i;
    take     = cmd_valid_i && (out_free || !produces);

    if (take && produces) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  assign cmd_pop_o   = take;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bad_q <= 1'b0;
      type_q      <= '0;
      count_q     <= '0;
      addr_q      <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        start_bad_q <= start_bad_d;
        type_q      <= type_d;
        count_q     <= count_d;
        addr_q      <= addr_d;
        sum_q       <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && produces) begin
      res_q <= res_d;
    end
  end

  `SLL_ASSERT_IMPL(a_take_has_room, clk_i, rst_ni, take && produces, out_free)
  `SLL_ASSERT_IMPL(a_pop_has_word, clk_i, rst_ni, cmd_pop_o, cmd_valid_i)
  `SLL_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, res_valid_q && !res_pop_i,
                   res_valid_q && $stable(res_q))
  `SLL_ASSERT_IMPL(a_write_clean, clk_i, rst_ni,
                   res_valid_q && (res_q.kind == KIND_WRITE),
                   (res_q.status == STATUS_OK) && (res_q.record_address == '0))

endmodule

`default_nettype wire

>>> hdl/srecord_line_loader.sv
// Channel   Direction  Handshake                     Word
// -------   ---------  ----------------------------  ---------------------------------
// in        sink       push / full                   char_code_i, last_char_i
// out       source     empty / pop                   kind_o ... record_type_o
// cfg       APB slave  psel, penable, pwrite, pready forced_base at byte address 0
//
// One character is taken every cycle while full is low; full rises only when the two-entry command
// queue is occupied because the result register is not being drained.
// A character's word is first written into the command queue, then passes through the record
// engine into the result register, where the result it causes is shown.
// A waiting result does not hold up characters that give no result.
// Reset is asynchronous and active low; there is no clearing pass.
`default_nettype none

module srecord_line_loader (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                push,
  output logic                                full,
  input  logic [sll_pkg::CHAR_BITS-1:0]       char_code_i,
  input  logic                                last_char_i,

  output logic                                empty,
  input  logic                                pop,
  output logic                                kind_o,
  output logic [sll_pkg::ADDR_BITS-1:0]       write_address_o,
  output logic [sll_pkg::DATA_BITS-1:0]       write_data_o,
  output logic [sll_pkg::STATUS_BITS-1:0]     status_o,
  output logic [sll_pkg::ADDR_BITS-1:0]       record_address_o,
  output logic [sll_pkg::COUNT_BITS-1:0]      byte_count_o,
  output logic                                checksum_ok_o,
  output logic [sll_pkg::TYPE_BITS-1:0]       record_type_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sll_pkg::REG_ADDR_BITS-1:0]   paddr,
  input  logic [sll_pkg::REG_BITS-1:0]        pwdata,
  output logic [sll_pkg::REG_BITS-1:0]        prdata,
  output logic                                pready
);
  import sll_pkg::*;

  logic [ADDR_BITS-1:0] forced_base_q;
  logic                 cmd_push, q_full, cmd_valid, cmd_pop;
  cmd_t                 cmd_in, cmd_out;
  logic                 res_valid, res_pop;
  res_t                 res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FORCED_BASE) ? forced_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forced_base_q <= '0;
    end else if (psel && penable && pwrite && (paddr == REG_FORCED_BASE)) begin
      forced_base_q <= pwdata;
    end
  end

  assign full = q_full;

  sll_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_push_i   (push),
    .q_full_i    (q_full),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  sll_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  assign res_pop = pop && res_valid;

  sll_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .forced_base_i (forced_base_q),
    .res_pop_i     (res_pop),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign empty            = !res_valid;
  assign kind_o           = res.kind;
  assign write_address_o  = res.write_address;
  assign write_data_o     = res.write_data;
  assign status_o         = res.status;
  assign record_address_o = res.record_address;
  assign byte_count_o     = res.byte_count;
  assign checksum_ok_o    = res.checksum_ok;
  assign record_type_o    = res.record_type;

endmodule

`default_nettype wire
